/* design/vfrp_pkg.sv */
// Shared types and constants of the vector font record parser.
// No dependencies; every other design file refers to this package by scoped names.
package vfrp_pkg;

   localparam int TABLE_ENTRIES = 96;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SCAN_W = $clog2(TABLE_ENTRIES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_Y_ZERO  = 8'h52;

   localparam logic [10:0] ID_LAST_POS     = 11'd4;
   localparam logic [10:0] COUNT_LAST_POS  = 11'd2;
   localparam logic [10:0] MARGIN_LAST_POS = 11'd2;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_BYTE = 2'd1,
      KIND_READ = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RES_START    = 2'd0,
      RES_DATA     = 2'd1,
      RES_READBACK = 2'd2
   } result_type;

   typedef enum logic [1:0] {
      PHASE_ID    = 2'd0,
      PHASE_COUNT = 2'd1,
      PHASE_DATA  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_SCAN_ID,
      ST_SCAN_COUNT,
      ST_START,
      ST_READ
   } back_state_type;

   typedef struct packed {
      kind_type    op;
      logic [6:0]  entry_index;
      logic [16:0] glyph_number;
      logic [7:0]  stream_byte;
   } cmd_type;

endpackage

/* design/vector_font_record_parser_unit.sv */
// Vector font record parser, top level.
// Requests go in through a queue-like port: a request is taken on a clock edge
// with push high and full low. Kind 0 loads a glyph number into a selection table
// slot, kind 1 feeds one font byte, kind 2 reads back a slot with the y range.
// Newline bytes and kind 3 are dropped at the front end and give no response.
// Responses come out the same way: the oldest one is on the rsp_ ports while
// empty is low and leaves on an edge with pop high.
// A request passes the front register and a four-entry command queue before the
// back end writes its response register; a readback first passes the table read
// register and the read state. The last byte of an id or of a pair count starts a
// serial scan of the table memory: 96 reads at one entry per cycle and a final
// compare, and a selected id then also writes its start response, which waits for
// a free response register. These scans set the worst case per request.
// A stalled receiver holds the response register; the back end then waits on
// requests that make a response while the queue keeps taking requests until full.
// Synchronous reset returns the parser to the id field with an empty queue and
// zero y range; the selection table is not cleared and must be loaded first.
// Depends on vfrp_pkg, vfrp_front, vfrp_cmd_queue and vfrp_back.
module vector_font_record_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_kind,
   input  logic [6:0]        req_entry_index,
   input  logic [16:0]       req_glyph_number,
   input  logic [7:0]        req_stream_byte,
   output logic              empty,
   input  logic              pop,
   output logic [1:0]        rsp_result_kind,
   output logic [16:0]       rsp_glyph_id,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_last_of_glyph,
   output logic [16:0]       rsp_entry_glyph,
   output logic [9:0]        rsp_entry_pairs,
   output logic [7:0]        rsp_top_y,
   output logic signed [7:0] rsp_bottom_y
);

   logic              front_valid;
   vfrp_pkg::cmd_type front_cmd;
   logic              queue_ready;
   logic              queue_valid;
   vfrp_pkg::cmd_type queue_cmd;
   logic              queue_pop;

   vfrp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_glyph_number (req_glyph_number),
      .req_stream_byte  (req_stream_byte),
      .cmd_valid        (front_valid),
      .cmd              (front_cmd),
      .cmd_taken        (queue_ready)
   );

   vfrp_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_cmd   (front_cmd),
      .wr_ready (queue_ready),
      .rd_valid (queue_valid),
      .rd_cmd   (queue_cmd),
      .rd_pop   (queue_pop)
   );

   vfrp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (queue_valid),
      .cmd               (queue_cmd),
      .cmd_pop           (queue_pop),
      .pop               (pop),
      .empty             (empty),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_glyph_id      (rsp_glyph_id),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_glyph (rsp_last_of_glyph),
      .rsp_entry_glyph   (rsp_entry_glyph),
      .rsp_entry_pairs   (rsp_entry_pairs),
      .rsp_top_y         (rsp_top_y),
      .rsp_bottom_y      (rsp_bottom_y)
   );

endmodule

/* design/vfrp_front.sv */
// Front end: takes requests, drops newline bytes and unknown kinds, and
// holds one classified command for the queue. Depends on vfrp_pkg.
module vfrp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_kind,
   input  logic [6:0]        req_entry_index,
   input  logic [16:0]       req_glyph_number,
   input  logic [7:0]        req_stream_byte,
   output logic              cmd_valid,
   output vfrp_pkg::cmd_type cmd,
   input  logic              cmd_taken
);

   logic              valid_ff, valid_in;
   vfrp_pkg::cmd_type cmd_ff, cmd_in;
   logic              keep;
   logic              accept;

   assign full      = valid_ff && !cmd_taken;
   assign accept    = push && !full;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      case (vfrp_pkg::kind_type'(req_kind))
         vfrp_pkg::KIND_LOAD: keep = 1'b1;
         vfrp_pkg::KIND_READ: keep = 1'b1;
         vfrp_pkg::KIND_BYTE: keep = (req_stream_byte != vfrp_pkg::CHAR_NEWLINE);
         default:             keep = 1'b0;
      endcase
   end

   always_comb begin
      cmd_in = cmd_ff;
      valid_in = valid_ff && !cmd_taken;
      if (accept) begin
         valid_in = keep;
         cmd_in.op = vfrp_pkg::kind_type'(req_kind);
         cmd_in.entry_index = req_entry_index;
         cmd_in.glyph_number = req_glyph_number;
         cmd_in.stream_byte = req_stream_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

/* design/vfrp_cmd_queue.sv */
// Short command queue between the front end and the back end.
// Depends on vfrp_pkg for the command type and the depth.
module vfrp_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  vfrp_pkg::cmd_type wr_cmd,
   output logic              wr_ready,
   output logic              rd_valid,
   output vfrp_pkg::cmd_type rd_cmd,
   input  logic              rd_pop
);

   vfrp_pkg::cmd_type                 slot_ff [vfrp_pkg::QUEUE_DEPTH];
   logic [vfrp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [vfrp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [vfrp_pkg::QPTR_W:0]         count_ff, count_in;
   logic                              do_wr, do_rd;

   assign wr_ready = (count_ff != (vfrp_pkg::QPTR_W + 1)'(vfrp_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + vfrp_pkg::QPTR_W'(do_wr);
      rd_ptr_in = rd_ptr_ff + vfrp_pkg::QPTR_W'(do_rd);
      count_in  = count_ff + (vfrp_pkg::QPTR_W + 1)'(do_wr)
                  - (vfrp_pkg::QPTR_W + 1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

/* design/vfrp_back.sv */
// Back end: record parser, glyph selection table memories with serial scans,
// and the response register. Depends on vfrp_pkg.
module vfrp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  vfrp_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              pop,
   output logic              empty,
   output logic [1:0]        rsp_result_kind,
   output logic [16:0]       rsp_glyph_id,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_last_of_glyph,
   output logic [16:0]       rsp_entry_glyph,
   output logic [9:0]        rsp_entry_pairs,
   output logic [7:0]        rsp_top_y,
   output logic signed [7:0] rsp_bottom_y
);

   localparam int IW = vfrp_pkg::IDX_W;
   localparam int SW = vfrp_pkg::SCAN_W;

   logic [16:0] glyph_mem [vfrp_pkg::TABLE_ENTRIES];
   logic [9:0]  pairs_mem [vfrp_pkg::TABLE_ENTRIES];

   vfrp_pkg::back_state_type state_ff, state_in;
   vfrp_pkg::phase_type      phase_ff, phase_in;
   logic [10:0] pos_ff, pos_in;
   logic [16:0] acc_ff, acc_in;
   logic        stopped_ff, stopped_in;
   logic        seen_ff, seen_in;
   logic [16:0] rec_id_ff, rec_id_in;
   logic [9:0]  rec_pairs_ff, rec_pairs_in;
   logic        sel_ff, sel_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  low_ff, low_in;
   logic [SW-1:0] scan_addr_ff, scan_addr_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0] cmp_addr_ff, cmp_addr_in;
   logic          found_ff, found_in;
   logic [16:0]   rd_glyph_ff;
   logic [9:0]    rd_pairs_ff;
   logic          rd_oor_ff, rd_oor_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [16:0] out_id_ff, out_id_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic [16:0] out_eglyph_ff, out_eglyph_in;
   logic [9:0]  out_epairs_ff, out_epairs_in;
   logic [7:0]  out_top_ff, out_top_in;
   logic [7:0]  out_bottom_ff, out_bottom_in;

   logic [7:0]  ch;
   logic        is_digit, is_space;
   logic [16:0] acc_take;
   logic        stopped_take, seen_take;
   logic [10:0] total;
   logic        last;
   logic signed [8:0] y_off;
   logic        need_out, byte_go, out_free, in_range;
   logic        id_end, count_end, scan_issue, scan_done, match;
   logic        glyph_wr, glyph_rd_en, pairs_wr, pairs_rd_en;
   logic [IW-1:0] glyph_rd_addr, cmd_addr;

   assign ch       = cmd.stream_byte;
   assign out_free = !out_valid_ff || pop;
   assign cmd_addr = IW'(cmd.entry_index);
   assign in_range = (32'(cmd.entry_index) < 32'(vfrp_pkg::TABLE_ENTRIES));
   assign total    = {rec_pairs_ff, 1'b0};
   assign last     = (pos_ff >= total - 11'd1);
   assign y_off    = $signed({1'b0, ch}) - $signed({1'b0, vfrp_pkg::CHAR_Y_ZERO});
   assign need_out = (phase_ff == vfrp_pkg::PHASE_DATA) && (total != '0) && sel_ff;
   assign byte_go  = cmd_valid && (cmd.op == vfrp_pkg::KIND_BYTE) && (!need_out || out_free);
   assign id_end   = (phase_ff != vfrp_pkg::PHASE_COUNT) && (phase_ff != vfrp_pkg::PHASE_DATA)
                     && (pos_ff >= vfrp_pkg::ID_LAST_POS);
   assign count_end  = (phase_ff == vfrp_pkg::PHASE_COUNT) && (pos_ff == vfrp_pkg::COUNT_LAST_POS);
   assign scan_issue = (scan_addr_ff < SW'(vfrp_pkg::TABLE_ENTRIES));
   assign scan_done  = cmp_valid_ff && (cmp_addr_ff == IW'(vfrp_pkg::TABLE_ENTRIES - 1));
   assign match      = cmp_valid_ff && (rd_glyph_ff == rec_id_ff);

   // atoi-style digit accumulation for the id and count fields.
   always_comb begin
      is_digit = (ch >= vfrp_pkg::CHAR_ZERO) && (ch <= vfrp_pkg::CHAR_NINE);
      is_space = (ch == vfrp_pkg::CHAR_SPACE) || (ch inside {[vfrp_pkg::CHAR_TAB:vfrp_pkg::CHAR_CR]});
      acc_take = acc_ff;
      stopped_take = stopped_ff;
      seen_take = seen_ff;
      if (!stopped_ff && !(!seen_ff && is_space)) begin
         if (is_digit) begin
            acc_take = (acc_ff << 3) + (acc_ff << 1) + {13'd0, ch[3:0]};
            seen_take = 1'b1;
         end else begin
            stopped_take = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfrp_pkg::ST_RUN: begin
            if (cmd_valid && cmd.op == vfrp_pkg::KIND_READ) begin
               state_in = vfrp_pkg::ST_READ;
            end else if (byte_go && id_end) begin
               state_in = vfrp_pkg::ST_SCAN_ID;
            end else if (byte_go && count_end) begin
               state_in = vfrp_pkg::ST_SCAN_COUNT;
            end
         end
         vfrp_pkg::ST_SCAN_ID: begin
            if (scan_done) begin
               state_in = (found_ff || match) ? vfrp_pkg::ST_START : vfrp_pkg::ST_RUN;
            end
         end
         vfrp_pkg::ST_SCAN_COUNT: begin
            if (scan_done) begin
               state_in = vfrp_pkg::ST_RUN;
            end
         end
         vfrp_pkg::ST_START: begin
            if (out_free) begin
               state_in = vfrp_pkg::ST_RUN;
            end
         end
         vfrp_pkg::ST_READ: begin
            if (out_free) begin
               state_in = vfrp_pkg::ST_RUN;
            end
         end
         default: state_in = vfrp_pkg::ST_RUN;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      acc_in = acc_ff;
      stopped_in = stopped_ff;
      seen_in = seen_ff;
      rec_id_in = rec_id_ff;
      rec_pairs_in = rec_pairs_ff;
      sel_in = sel_ff;
      high_in = high_ff;
      low_in = low_ff;
      scan_addr_in = scan_addr_ff;
      cmp_valid_in = 1'b0;
      cmp_addr_in = cmp_addr_ff;
      found_in = found_ff;
      rd_oor_in = rd_oor_ff;
      cmd_pop = 1'b0;
      glyph_wr = 1'b0;
      glyph_rd_en = 1'b0;
      glyph_rd_addr = cmd_addr;
      pairs_wr = 1'b0;
      pairs_rd_en = 1'b0;
      out_valid_in = out_valid_ff && !pop;
      out_kind_in = out_kind_ff;
      out_id_in = out_id_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_eglyph_in = out_eglyph_ff;
      out_epairs_in = out_epairs_ff;
      out_top_in = out_top_ff;
      out_bottom_in = out_bottom_ff;

      case (state_ff)
         vfrp_pkg::ST_RUN: begin
            scan_addr_in = '0;
            found_in = 1'b0;
            if (cmd_valid) begin
               case (cmd.op)
                  vfrp_pkg::KIND_LOAD: begin
                     cmd_pop = 1'b1;
                     glyph_wr = in_range;
                  end
                  vfrp_pkg::KIND_READ: begin
                     cmd_pop = 1'b1;
                     glyph_rd_en = 1'b1;
                     pairs_rd_en = 1'b1;
                     rd_oor_in = !in_range;
                  end
                  vfrp_pkg::KIND_BYTE: begin
                     cmd_pop = byte_go;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
            if (byte_go) begin
               case (phase_ff)
                  vfrp_pkg::PHASE_COUNT: begin
                     acc_in = acc_take;
                     stopped_in = stopped_take;
                     seen_in = seen_take;
                     if (count_end) begin
                        rec_pairs_in = acc_take[9:0];
                        phase_in = vfrp_pkg::PHASE_DATA;
                        pos_in = '0;
                     end else begin
                        pos_in = pos_ff + 11'd1;
                     end
                  end
                  vfrp_pkg::PHASE_DATA: begin
                     if (total == '0 || last) begin
                        phase_in = vfrp_pkg::PHASE_ID;
                        pos_in = '0;
                        acc_in = '0;
                        stopped_in = 1'b0;
                        seen_in = 1'b0;
                     end else begin
                        pos_in = pos_ff + 11'd1;
                     end
                     // Y characters sit at odd positions after the margin pair.
                     if (total != '0 && sel_ff && pos_ff > vfrp_pkg::MARGIN_LAST_POS
                         && pos_ff[0]) begin
                        if (y_off > $signed({1'b0, high_ff})) begin
                           high_in = y_off[7:0];
                        end
                        if (y_off < $signed({low_ff[7], low_ff})) begin
                           low_in = y_off[7:0];
                        end
                     end
                     if (need_out) begin
                        out_valid_in = 1'b1;
                        out_kind_in = vfrp_pkg::RES_DATA;
                        out_id_in = rec_id_ff;
                        out_byte_in = ch;
                        out_last_in = last;
                        out_eglyph_in = '0;
                        out_epairs_in = '0;
                        out_top_in = '0;
                        out_bottom_in = '0;
                     end
                  end
                  default: begin
                     if (id_end) begin
                        rec_id_in = acc_take;
                        phase_in = vfrp_pkg::PHASE_COUNT;
                        pos_in = '0;
                        acc_in = '0;
                        stopped_in = 1'b0;
                        seen_in = 1'b0;
                     end else begin
                        acc_in = acc_take;
                        stopped_in = stopped_take;
                        seen_in = seen_take;
                        phase_in = vfrp_pkg::PHASE_ID;
                        pos_in = pos_ff + 11'd1;
                     end
                  end
               endcase
            end
         end
         vfrp_pkg::ST_SCAN_ID, vfrp_pkg::ST_SCAN_COUNT: begin
            // One entry is read per cycle and compared in the next one.
            glyph_rd_en = scan_issue;
            glyph_rd_addr = scan_addr_ff[IW-1:0];
            cmp_valid_in = scan_issue;
            cmp_addr_in = scan_addr_ff[IW-1:0];
            scan_addr_in = scan_addr_ff + SW'(scan_issue);
            found_in = found_ff || match;
            pairs_wr = (state_ff == vfrp_pkg::ST_SCAN_COUNT) && match;
            if (state_ff == vfrp_pkg::ST_SCAN_ID && scan_done) begin
               sel_in = found_ff || match;
            end
         end
         vfrp_pkg::ST_START: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in = vfrp_pkg::RES_START;
               out_id_in = rec_id_ff;
               out_byte_in = '0;
               out_last_in = 1'b0;
               out_eglyph_in = '0;
               out_epairs_in = '0;
               out_top_in = '0;
               out_bottom_in = '0;
            end
         end
         vfrp_pkg::ST_READ: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in = vfrp_pkg::RES_READBACK;
               out_id_in = '0;
               out_byte_in = '0;
               out_last_in = 1'b0;
               out_eglyph_in = rd_oor_ff ? 17'd0 : rd_glyph_ff;
               out_epairs_in = rd_oor_ff ? 10'd0 : rd_pairs_ff;
               out_top_in = high_ff;
               out_bottom_in = low_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (glyph_wr) begin
         glyph_mem[cmd_addr] <= cmd.glyph_number;
      end
      if (glyph_rd_en) begin
         rd_glyph_ff <= glyph_mem[glyph_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pairs_wr) begin
         pairs_mem[cmp_addr_ff] <= rec_pairs_ff;
      end
      if (pairs_rd_en) begin
         rd_pairs_ff <= pairs_mem[cmd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfrp_pkg::ST_RUN;
         phase_ff     <= vfrp_pkg::PHASE_ID;
         pos_ff       <= '0;
         acc_ff       <= '0;
         stopped_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         rec_id_ff    <= '0;
         rec_pairs_ff <= '0;
         sel_ff       <= 1'b0;
         high_ff      <= '0;
         low_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         stopped_ff   <= stopped_in;
         seen_ff      <= seen_in;
         rec_id_ff    <= rec_id_in;
         rec_pairs_ff <= rec_pairs_in;
         sel_ff       <= sel_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
      scan_addr_ff  <= scan_addr_in;
      cmp_addr_ff   <= cmp_addr_in;
      rd_oor_ff     <= rd_oor_in;
      out_kind_ff   <= out_kind_in;
      out_id_ff     <= out_id_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_eglyph_ff <= out_eglyph_in;
      out_epairs_ff <= out_epairs_in;
      out_top_ff    <= out_top_in;
      out_bottom_ff <= out_bottom_in;
   end

   assign empty             = !out_valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_glyph_id      = out_id_ff;
   assign rsp_data_byte     = out_byte_ff;
   assign rsp_last_of_glyph = out_last_ff;
   assign rsp_entry_glyph   = out_eglyph_ff;
   assign rsp_entry_pairs   = out_epairs_ff;
   assign rsp_top_y         = out_top_ff;
   assign rsp_bottom_y      = $signed(out_bottom_ff);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for vector_font_record_parser_unit: table loads, font bytes and readbacks are
// sent at random pace and every response is checked against a built-in parser predictor.
// Depends on vfrp_pkg and the parser design files; it reads no files.
module tb_top;
   import vfrp_pkg::*;

   localparam int RANDOM_REQUESTS = 1850;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      result_type  kind;
      logic [16:0] glyph_id;
      logic [7:0]  data_byte;
      logic        last;
      logic [16:0] entry_glyph;
      logic [9:0]  entry_pairs;
      logic [7:0]  top_y;
      logic [7:0]  bottom_y;
   } glyph_result_type;

   typedef enum {DRAIN_ALL, DRAIN_HALF, DRAIN_QUARTER, DRAIN_MOST} drain_mode_type;

   // Tracks the parser state and table, and holds the responses still to come.
   class glyph_scoreboard_type;
      phase_type         phase;
      logic [10:0]       position;
      logic [16:0]       number;
      bit                stopped;
      bit                digit_seen;
      logic [16:0]       record_id;
      logic [9:0]        record_pairs;
      bit                selected;
      logic [16:0]       slot_glyph [TABLE_ENTRIES];
      logic [9:0]        slot_pairs [TABLE_ENTRIES];
      bit                slot_counted [TABLE_ENTRIES];
      logic [7:0]        top_y;
      logic signed [7:0] bottom_y;
      glyph_result_type  awaited [$];
      int                errors;
      int                starts_seen;
      int                bytes_seen;
      int                reads_seen;

      function new();
         restart_record();
         record_id = '0;
         record_pairs = '0;
         selected = 1'b0;
         top_y = '0;
         bottom_y = '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_glyph[i] = '0;
            slot_pairs[i] = '0;
            slot_counted[i] = 1'b0;
         end
      endfunction

      task report(string text);
         errors++;
         $display("mismatch: %s", text);
      endtask

      function void restart_record();
         phase = PHASE_ID;
         position = '0;
         number = '0;
         stopped = 1'b0;
         digit_seen = 1'b0;
      endfunction

      function bit at_record_start();
         return phase == PHASE_ID && position == 0;
      endfunction

      function bit holds_glyph(logic [16:0] glyph);
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_glyph[i] == glyph) return 1'b1;
         return 1'b0;
      endfunction

      // A random slot whose pair count has been written; -1 while there are none.
      function int readable_slot();
         int start;
         start = $urandom_range(0, TABLE_ENTRIES - 1);
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_counted[(start + i) % TABLE_ENTRIES]) return (start + i) % TABLE_ENTRIES;
         return -1;
      endfunction

      function glyph_result_type blank_result(result_type kind);
         glyph_result_type r;
         r.kind = kind;
         r.glyph_id = '0;
         r.data_byte = '0;
         r.last = 1'b0;
         r.entry_glyph = '0;
         r.entry_pairs = '0;
         r.top_y = '0;
         r.bottom_y = '0;
         return r;
      endfunction

      // Decimal conversion like atoi but with no sign: leading white space, stop at a non-digit.
      function void take_digit(logic [7:0] c);
         if (stopped) return;
         if (!digit_seen && (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) return;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            number = number * 17'd10 + 17'(c - CHAR_ZERO);
            digit_seen = 1'b1;
         end else begin
            stopped = 1'b1;
         end
      endfunction

      function void take_byte(logic [7:0] c);
         glyph_result_type r;
         logic [10:0]      total;
         bit               last;
         int               y;
         if (c == CHAR_NEWLINE) return;
         case (phase)
            PHASE_COUNT: begin
               take_digit(c);
               if (position == COUNT_LAST_POS) begin
                  record_pairs = number[9:0];
                  for (int i = 0; i < TABLE_ENTRIES; i++)
                     if (slot_glyph[i] == record_id) begin
                        slot_pairs[i] = record_pairs;
                        slot_counted[i] = 1'b1;
                     end
                  phase = PHASE_DATA;
                  position = '0;
               end else begin
                  position++;
               end
            end
            PHASE_DATA: begin
               total = {record_pairs, 1'b0};
               if (total == 0) begin
                  // An empty record still swallows one byte, silently.
                  restart_record();
                  return;
               end
               if (selected && position > MARGIN_LAST_POS && position[0]) begin
                  y = int'(c) - int'(CHAR_Y_ZERO);
                  if (y > int'(top_y)) top_y = 8'(y);
                  if (y < int'(bottom_y)) bottom_y = 8'(y);
               end
               last = position >= total - 11'd1;
               if (selected) begin
                  r = blank_result(RES_DATA);
                  r.glyph_id = record_id;
                  r.data_byte = c;
                  r.last = last;
                  awaited.push_back(r);
               end
               if (last) restart_record();
               else position++;
            end
            default: begin
               phase = PHASE_ID;
               take_digit(c);
               if (position >= ID_LAST_POS) begin
                  record_id = number;
                  selected = holds_glyph(number);
                  restart_record();
                  phase = PHASE_COUNT;
                  if (selected) begin
                     r = blank_result(RES_START);
                     r.glyph_id = record_id;
                     awaited.push_back(r);
                  end
               end else begin
                  position++;
               end
            end
         endcase
      endfunction

      function void note_request(kind_type kind, logic [6:0] idx, logic [16:0] glyph,
                                 logic [7:0] value);
         glyph_result_type r;
         case (kind)
            KIND_LOAD: if (idx < TABLE_ENTRIES) slot_glyph[idx] = glyph;
            KIND_BYTE: take_byte(value);
            KIND_READ: begin
               r = blank_result(RES_READBACK);
               if (idx < TABLE_ENTRIES) begin
                  r.entry_glyph = slot_glyph[idx];
                  r.entry_pairs = slot_pairs[idx];
               end
               r.top_y = top_y;
               r.bottom_y = bottom_y;
               awaited.push_back(r);
            end
            default: ;
         endcase
      endfunction

      task compare(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_response(logic [1:0] kind, logic [16:0] glyph_id,
                          logic [7:0] data_byte, logic last,
                          logic [16:0] entry_glyph, logic [9:0] entry_pairs,
                          logic [7:0] top, logic [7:0] bottom);
         glyph_result_type e;
         if (awaited.size() == 0) begin
            report($sformatf("response of kind %0d with no request behind it", kind));
            return;
         end
         e = awaited.pop_front();
         case (e.kind)
            RES_START: starts_seen++;
            RES_DATA:  bytes_seen++;
            default:   reads_seen++;
         endcase
         compare("result_kind", kind, e.kind);
         compare("glyph_id", glyph_id, e.glyph_id);
         compare("data_byte", data_byte, e.data_byte);
         compare("last_of_glyph", last, e.last);
         compare("entry_glyph", entry_glyph, e.entry_glyph);
         compare("entry_pairs", entry_pairs, e.entry_pairs);
         compare("top_y", top, e.top_y);
         compare("bottom_y", bottom, e.bottom_y);
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [1:0]        req_kind = KIND_LOAD;
   logic [6:0]        req_entry_index = '0;
   logic [16:0]       req_glyph_number = '0;
   logic [7:0]        req_stream_byte = '0;
   logic              empty;
   logic              pop = 1'b0;
   logic [1:0]        rsp_result_kind;
   logic [16:0]       rsp_glyph_id;
   logic [7:0]        rsp_data_byte;
   logic              rsp_last_of_glyph;
   logic [16:0]       rsp_entry_glyph;
   logic [9:0]        rsp_entry_pairs;
   logic [7:0]        rsp_top_y;
   logic signed [7:0] rsp_bottom_y;

   glyph_scoreboard_type sb;
   int             burst_left = 0;
   int             requests_counted = 0;
   int             cycles = 0;
   logic           hold_req = 1'b0;
   bit             hold_taken = 1'b0;
   int             hold_left = 0;
   int             stall_span = 0;
   drain_mode_type drain_mode = DRAIN_ALL;

   vector_font_record_parser_unit uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_glyph_number  (req_glyph_number),
      .req_stream_byte   (req_stream_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_glyph_id      (rsp_glyph_id),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_glyph (rsp_last_of_glyph),
      .rsp_entry_glyph   (rsp_entry_glyph),
      .rsp_entry_pairs   (rsp_entry_pairs),
      .rsp_top_y         (rsp_top_y),
      .rsp_bottom_y      (rsp_bottom_y)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Receiver: pops on a drain pattern that is picked anew at random whenever its span
   // runs out, and once holds off entirely so that the parser backs up and raises full.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            sb.check_response(rsp_result_kind, rsp_glyph_id, rsp_data_byte,
                              rsp_last_of_glyph, rsp_entry_glyph, rsp_entry_pairs,
                              rsp_top_y, rsp_bottom_y);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (stall_span == 0) begin
            drain_mode = drain_mode_type'($urandom_range(0, 3));
            stall_span = $urandom_range(50, 300);
         end
         stall_span--;
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            case (drain_mode)
               DRAIN_ALL:     pop <= 1'b1;
               DRAIN_HALF:    pop <= 1'($urandom_range(0, 1));
               DRAIN_QUARTER: pop <= (stall_span % 4 == 0);
               default:       pop <= ($urandom_range(0, 6) != 0);
            endcase
         end
      end
   end

   // Offers one request in bursts with random gaps, and waits until it is taken.
   task automatic offer(kind_type kind, logic [6:0] idx, logic [16:0] glyph,
                        logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      push <= 1'b1;
      req_kind <= kind;
      req_entry_index <= idx;
      req_glyph_number <= glyph;
      req_stream_byte <= value;
      do @(posedge clock); while (full);
      sb.note_request(kind, idx, glyph, value);
      if (!(kind == KIND_NONE || (kind == KIND_BYTE && value == CHAR_NEWLINE)))
         requests_counted++;
   endtask

   task automatic put_byte(logic [7:0] value);
      offer(KIND_BYTE, 7'($urandom_range(0, 127)), 17'($urandom_range(0, 99999)), value);
   endtask

   task automatic put_str(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_read();
      int slot;
      slot = sb.readable_slot();
      if (slot < 0 || $urandom_range(0, 7) == 0) slot = $urandom_range(TABLE_ENTRIES, 127);
      offer(KIND_READ, 7'(slot), 17'($urandom_range(0, 99999)), 8'($urandom_range(0, 255)));
   endtask

   // A decimal field padded to its width with zeros or white space.
   task automatic put_field(int value, int width);
      logic [7:0] digits [$];
      logic [7:0] pad;
      int         v;
      int         style;
      v = value;
      do begin
         digits.push_front(8'(CHAR_ZERO + v % 10));
         v = v / 10;
      end while (v > 0);
      style = $urandom_range(0, 3);
      for (int i = digits.size(); i < width; i++) begin
         case (style)
            0, 1: pad = CHAR_SPACE;
            2:    pad = CHAR_ZERO;
            default: begin
               pad = 8'($urandom_range(CHAR_TAB, CHAR_CR + 1));
               if (pad == CHAR_CR + 1 || pad == CHAR_NEWLINE) pad = CHAR_SPACE;
            end
         endcase
         put_byte(pad);
      end
      foreach (digits[i]) put_byte(digits[i]);
   endtask

   task automatic put_record(logic [16:0] id, int npairs);
      logic [7:0] c;
      // Bring the parser back to the start of a record after noise.
      while (!sb.at_record_start()) put_byte("x");
      put_field(int'(id), 5);
      put_field(npairs, 3);
      if (npairs == 0) put_byte(8'($urandom_range(33, 126)));
      for (int i = 0; i < 2 * npairs; i++) begin
         if ($urandom_range(0, 39) == 0) put_byte(CHAR_NEWLINE);
         if ($urandom_range(0, 59) == 0) put_read();
         if (i < 2) c = 8'($urandom_range("A", "Z"));
         else if (i % 2 == 1)
            c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(50, 114));
         else c = 8'($urandom_range(32, 126));
         if (c == CHAR_NEWLINE) c = CHAR_CR;
         put_byte(c);
      end
   endtask

   initial begin
      logic [16:0] glyph;
      int          base;
      int          pick;
      int          npairs;
      bit          pressed;
      sb = new();
      pressed = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every slot is loaded before the first id is looked up.
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         glyph = (i == 0) ? 17'd0 : (i == 1) ? 17'd99999
               : (i == 2 || i == 3) ? 17'd12345 : 17'($urandom_range(0, 99999));
         offer(KIND_LOAD, 7'(i), glyph, 8'($urandom_range(0, 255)));
      end

      // Slots past the table end: the load is dropped and the read answers a zero glyph and pair count.
      offer(KIND_LOAD, 7'd127, 17'd99999, 8'hFF);
      offer(KIND_READ, 7'd127, 17'd0, 8'h00);
      offer(KIND_NONE, 7'd5, 17'd1, 8'h31);
      // Glyph 0 with y characters at both ends of the byte range.
      put_str("    0  3MRA");
      put_byte(8'hFF);
      put_byte(CHAR_NEWLINE);
      put_byte("B");
      put_byte(8'h00);
      offer(KIND_READ, 7'd0, 17'd0, 8'h00);
      // Zero pairs, then a count that lands in two slots with the same glyph.
      put_str("99999000Z");
      put_str("12345002ABCD");
      offer(KIND_READ, 7'd3, 17'd0, 8'h00);
      // Sign characters end the conversion.
      put_str("+1234-121");
      // A glyph loaded after its id has ended does not select the record.
      do glyph = 17'($urandom_range(0, 99999)); while (sb.holds_glyph(glyph));
      put_field(int'(glyph), 5);
      put_byte("0");
      offer(KIND_LOAD, 7'd4, glyph, 8'h00);
      put_str("01MR");
      offer(KIND_READ, 7'd4, 17'd0, 8'h00);

      base = requests_counted;
      while (requests_counted - base < RANDOM_REQUESTS) begin
         if (!pressed && requests_counted - base > 600) begin
            // Keep reads coming while the receiver holds off.
            pressed = 1'b1;
            hold_req <= 1'b1;
            burst_left = 200;
            repeat (32) put_read();
         end
         pick = $urandom_range(0, 99);
         if (pick < 66) begin
            glyph = ($urandom_range(0, 9) < 6) ? sb.slot_glyph[$urandom_range(0, TABLE_ENTRIES - 1)]
                                               : 17'($urandom_range(0, 99999));
            pick = $urandom_range(0, 99);
            npairs = (pick < 80) ? $urandom_range(0, 6)
                   : (pick < 96) ? $urandom_range(7, 30) : $urandom_range(31, 120);
            put_record(glyph, npairs);
         end else if (pick < 76) begin
            put_read();
         end else if (pick < 84) begin
            glyph = ($urandom_range(0, 1) == 1) ? sb.slot_glyph[$urandom_range(0, TABLE_ENTRIES - 1)]
                                                : 17'($urandom_range(0, 99999));
            offer(KIND_LOAD, 7'($urandom_range(0, 127)), glyph, 8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
         end else if (pick < 97) begin
            // A record cut short after its id.
            put_field($urandom_range(0, 99999), 5);
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
         end else if (pick < 99) begin
            offer(KIND_NONE, 7'($urandom_range(0, 127)), 17'($urandom_range(0, 99999)),
                  8'($urandom_range(0, 255)));
         end else begin
            put_byte(CHAR_NEWLINE);
         end
      end
      push <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests; checked %0d glyph starts, %0d data bytes, %0d readbacks.",
               requests_counted, sb.starts_seen, sb.bytes_seen, sb.reads_seen);
      $display("The receiver held off %0d cycles under load; %0d mismatches seen.",
               HOLD_CYCLES, sb.errors);
      if (sb.errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule
